// ===== design/tms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the temporal motion vector scaler.
// No dependencies.
package tms_pkg;

  localparam int DIST_W  = 16;
  localparam int VEC_W   = 16;
  localparam int TB_W    = 8;
  localparam int TXM_W   = 15;
  localparam int TX_W    = 16;
  localparam int PROD_W  = 24;
  localparam int SCALE_W = 13;
  localparam int P_W     = 29;
  localparam int STAGES  = 5;

  localparam logic signed [DIST_W-1:0] DIST_HI = 16'sd127;
  localparam logic signed [DIST_W-1:0] DIST_LO = -16'sd128;

  localparam logic signed [18:0] SCALE_HI = 19'sd4095;
  localparam logic signed [18:0] SCALE_LO = -19'sd4096;

  localparam logic signed [21:0] VEC_HI = 22'sd32767;
  localparam logic signed [21:0] VEC_LO = -22'sd32768;

  // (16384 + d/2) / d for d = 1..128, indexed by d-1
  localparam logic [TXM_W-1:0] TX_TABLE [128] = '{
    15'd16384, 15'd8192, 15'd5461, 15'd4096, 15'd3277, 15'd2731, 15'd2341, 15'd2048,
    15'd1820,  15'd1638, 15'd1489, 15'd1365, 15'd1260, 15'd1170, 15'd1092, 15'd1024,
    15'd964,   15'd910,  15'd862,  15'd819,  15'd780,  15'd745,  15'd712,  15'd683,
    15'd655,   15'd630,  15'd607,  15'd585,  15'd565,  15'd546,  15'd529,  15'd512,
    15'd496,   15'd482,  15'd468,  15'd455,  15'd443,  15'd431,  15'd420,  15'd410,
    15'd400,   15'd390,  15'd381,  15'd372,  15'd364,  15'd356,  15'd349,  15'd341,
    15'd334,   15'd328,  15'd321,  15'd315,  15'd309,  15'd303,  15'd298,  15'd293,
    15'd287,   15'd282,  15'd278,  15'd273,  15'd269,  15'd264,  15'd260,  15'd256,
    15'd252,   15'd248,  15'd245,  15'd241,  15'd237,  15'd234,  15'd231,  15'd228,
    15'd224,   15'd221,  15'd218,  15'd216,  15'd213,  15'd210,  15'd207,  15'd205,
    15'd202,   15'd200,  15'd197,  15'd195,  15'd193,  15'd191,  15'd188,  15'd186,
    15'd184,   15'd182,  15'd180,  15'd178,  15'd176,  15'd174,  15'd172,  15'd171,
    15'd169,   15'd167,  15'd165,  15'd164,  15'd162,  15'd161,  15'd159,  15'd158,
    15'd156,   15'd155,  15'd153,  15'd152,  15'd150,  15'd149,  15'd148,  15'd146,
    15'd145,   15'd144,  15'd142,  15'd141,  15'd140,  15'd139,  15'd138,  15'd137,
    15'd135,   15'd134,  15'd133,  15'd132,  15'd131,  15'd130,  15'd129,  15'd128
  };

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } tms_adv_t;

endpackage

// ===== design/tms_scale.sv =====
`timescale 1ns / 1ps
// Scale factor path: distance clipping, reciprocal lookup, tb*tx, rounding and clip.
// Depends on tms_pkg.
module tms_scale (
  input  logic                                 clk,
  input  tms_pkg::tms_adv_t                    adv,
  input  logic signed [tms_pkg::DIST_W-1:0]    cur_dist,
  input  logic signed [tms_pkg::DIST_W-1:0]    cand_dist,
  output logic signed [tms_pkg::SCALE_W-1:0]   scale,
  output logic                                 bypass
);
  import tms_pkg::*;

  logic signed [TB_W-1:0]   tb_clip;
  logic signed [TB_W-1:0]   td_clip;
  logic [TB_W-1:0]          td_mag;
  logic [6:0]               tx_idx;
  logic [TXM_W-1:0]         tx_mag;
  logic signed [TX_W-1:0]   tx_next;
  logic                     byp_next;

  logic signed [TB_W-1:0]   tb1;
  logic signed [TX_W-1:0]   tx1;
  logic                     byp1;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod2;
  logic                     byp2;
  logic signed [PROD_W:0]   rnd;
  logic signed [18:0]       shifted;
  logic signed [SCALE_W-1:0] scale_next;

  always_comb begin
    if (cur_dist > DIST_HI) begin
      tb_clip = TB_W'(DIST_HI);
    end else if (cur_dist < DIST_LO) begin
      tb_clip = TB_W'(DIST_LO);
    end else begin
      tb_clip = cur_dist[TB_W-1:0];
    end
    if (cand_dist > DIST_HI) begin
      td_clip = TB_W'(DIST_HI);
    end else if (cand_dist < DIST_LO) begin
      td_clip = TB_W'(DIST_LO);
    end else begin
      td_clip = cand_dist[TB_W-1:0];
    end
    td_mag   = td_clip[TB_W-1] ? TB_W'(-td_clip) : TB_W'(td_clip);
    tx_idx   = 7'(td_mag - 8'd1);
    tx_mag   = TX_TABLE[tx_idx];
    tx_next  = td_clip[TB_W-1] ? -$signed({1'b0, tx_mag}) : $signed({1'b0, tx_mag});
    byp_next = (cur_dist == cand_dist) || (td_clip == '0);
  end

  assign prod_next = tb1 * tx1;

  always_comb begin
    rnd     = (PROD_W+1)'(prod2) + 25'sd32;
    shifted = rnd[PROD_W:6];
    if (shifted > SCALE_HI) begin
      scale_next = SCALE_W'(SCALE_HI);
    end else if (shifted < SCALE_LO) begin
      scale_next = SCALE_W'(SCALE_LO);
    end else begin
      scale_next = shifted[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      tb1  <= tb_clip;
      tx1  <= tx_next;
      byp1 <= byp_next;
    end
    if (adv.s2) begin
      prod2 <= prod_next;
      byp2  <= byp1;
    end
    if (adv.s3) begin
      scale  <= scale_next;
      bypass <= byp2;
    end
  end

endmodule

// ===== design/tms_lane.sv =====
`timescale 1ns / 1ps
// One vector component lane: delay line, scale multiply, round and saturate.
// Depends on tms_pkg.
module tms_lane (
  input  logic                                 clk,
  input  tms_pkg::tms_adv_t                    adv,
  input  logic signed [tms_pkg::SCALE_W-1:0]   scale,
  input  logic                                 bypass,
  input  logic signed [tms_pkg::VEC_W-1:0]     vec_in,
  output logic signed [tms_pkg::VEC_W-1:0]     vec_out
);
  import tms_pkg::*;

  logic signed [VEC_W-1:0] v1;
  logic signed [VEC_W-1:0] v2;
  logic signed [VEC_W-1:0] v3;
  logic signed [VEC_W-1:0] v4;
  logic signed [P_W-1:0]   p_next;
  logic signed [P_W-1:0]   p4;
  logic                    byp4;
  logic signed [P_W:0]     rnd;
  logic signed [21:0]      shifted;
  logic signed [VEC_W-1:0] sat;

  assign p_next = scale * v3;

  always_comb begin
    rnd     = (P_W+1)'(p4) + (p4[P_W-1] ? 30'sd128 : 30'sd127);
    shifted = rnd[P_W:8];
    if (shifted > VEC_HI) begin
      sat = VEC_W'(VEC_HI);
    end else if (shifted < VEC_LO) begin
      sat = VEC_W'(VEC_LO);
    end else begin
      sat = shifted[VEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      v1 <= vec_in;
    end
    if (adv.s2) begin
      v2 <= v1;
    end
    if (adv.s3) begin
      v3 <= v2;
    end
    if (adv.s4) begin
      p4   <= p_next;
      v4   <= v3;
      byp4 <= bypass;
    end
    if (adv.s5) begin
      vec_out <= byp4 ? v4 : sat;
    end
  end

endmodule

// ===== design/temporal_mv_scaler.sv =====
`timescale 1ns / 1ps
// Temporal motion vector scaler top level: stage control and lane merge.
// Depends on tms_pkg, tms_scale, tms_lane.
//
// Usage:
//   Request in:  in_valid / in_stall with cur_dist, cand_dist, vec_x_in, vec_y_in.
//   Request out: out_valid / out_stall with vec_x_out, vec_y_out.
//   A request moves at a clock edge where valid is high and stall is low.
//   Throughput is one request per cycle while out_stall is low; every request yields one result.
//   Five register stages: clip and reciprocal lookup, tb*tx, scale rounding,
//   per-lane component multiply, per-lane round and saturate (output register).
//   Each stage advances when it is empty or the stage after it advances, so
//   empty slots close up while out_stall is high; in_stall rises only once
//   all five stages hold requests and the output is stalled.
//   Reset (rst, synchronous) empties the pipeline; out_valid is low after it.
module temporal_mv_scaler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tms_pkg::DIST_W-1:0]  cur_dist,
  input  logic signed [tms_pkg::DIST_W-1:0]  cand_dist,
  input  logic signed [tms_pkg::VEC_W-1:0]   vec_x_in,
  input  logic signed [tms_pkg::VEC_W-1:0]   vec_y_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tms_pkg::VEC_W-1:0]   vec_x_out,
  output logic signed [tms_pkg::VEC_W-1:0]   vec_y_out
);
  import tms_pkg::*;

  logic [STAGES-1:0]        vld;
  logic [STAGES-1:0]        rdy;
  tms_adv_t                 adv;
  logic signed [SCALE_W-1:0] scale;
  logic                     bypass;

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign adv       = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};
  assign in_stall  = !rdy[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  tms_scale u_scale (
    .clk       (clk),
    .adv       (adv),
    .cur_dist  (cur_dist),
    .cand_dist (cand_dist),
    .scale     (scale),
    .bypass    (bypass)
  );

  tms_lane u_lane_x (
    .clk     (clk),
    .adv     (adv),
    .scale   (scale),
    .bypass  (bypass),
    .vec_in  (vec_x_in),
    .vec_out (vec_x_out)
  );

  tms_lane u_lane_y (
    .clk     (clk),
    .adv     (adv),
    .scale   (scale),
    .bypass  (bypass),
    .vec_in  (vec_y_in),
    .vec_out (vec_y_out)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (&vld)))
    else $error("input stalled while pipeline has room");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!vld[STAGES-2] && !(out_valid && out_stall)) |=> !out_valid)
    else $error("result appeared without a request behind it");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for temporal_mv_scaler: directed and random motion vector requests
// checked against a built-in scaling predictor. Depends on tms_pkg and the RTL.
module testbench;
  import tms_pkg::*;

  localparam int TX_NUM         = 16384;
  localparam int SCALE_BIAS     = 32;
  localparam int SCALE_SHIFT    = 6;
  localparam int ROUND_BIAS     = 127;
  localparam int ROUND_SHIFT    = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
  } mv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DIST_W-1:0] cur_dist = '0;
  logic signed [DIST_W-1:0] cand_dist = '0;
  logic signed [VEC_W-1:0] vec_x_in = '0;
  logic signed [VEC_W-1:0] vec_y_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VEC_W-1:0] vec_x_out;
  logic signed [VEC_W-1:0] vec_y_out;

  mv_t expected_mv[$];
  int mismatch_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int stuck_cycles = 0;

  temporal_mv_scaler u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cur_dist  (cur_dist),
    .cand_dist (cand_dist),
    .vec_x_in  (vec_x_in),
    .vec_y_in  (vec_y_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .vec_x_out (vec_x_out),
    .vec_y_out (vec_y_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [VEC_W-1:0] round_component(input int scale,
                                                              input int v);
    int p;
    int r;
    p = scale * v;
    r = (p + ROUND_BIAS + ((p < 0) ? 1 : 0)) >>> ROUND_SHIFT;
    r = clamp(r, int'(VEC_LO), int'(VEC_HI));
    return r[VEC_W-1:0];
  endfunction

  function automatic mv_t scale_mv(input logic signed [DIST_W-1:0] tb_raw,
                                   input logic signed [DIST_W-1:0] td_raw,
                                   input logic signed [VEC_W-1:0] vx,
                                   input logic signed [VEC_W-1:0] vy);
    int tb;
    int td;
    int half;
    int tx;
    int scale;
    mv_t r;
    r.x = vx;
    r.y = vy;
    if (tb_raw == td_raw) return r;
    tb = clamp(int'(tb_raw), int'(DIST_LO), int'(DIST_HI));
    td = clamp(int'(td_raw), int'(DIST_LO), int'(DIST_HI));
    if (td == 0) return r;
    half = td / 2;
    if (half < 0) half = -half;
    tx = (TX_NUM + half) / td;
    scale = clamp((tb * tx + SCALE_BIAS) >>> SCALE_SHIFT, int'(SCALE_LO), int'(SCALE_HI));
    r.x = round_component(scale, int'(vx));
    r.y = round_component(scale, int'(vy));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_mv(input logic signed [DIST_W-1:0] tb,
                         input logic signed [DIST_W-1:0] td,
                         input logic signed [VEC_W-1:0] vx,
                         input logic signed [VEC_W-1:0] vy);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cur_dist  <= tb;
    cand_dist <= td;
    vec_x_in  <= vx;
    vec_y_in  <= vy;
    do @(posedge clk); while (in_stall);
    expected_mv.push_back(scale_mv(tb, td, vx, vy));
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    mv_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_mv.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d", vec_x_out, vec_y_out));
      end else begin
        want = expected_mv.pop_front();
        if (vec_x_out !== want.x)
          report_mismatch($sformatf("vec_x_out got %0d want %0d", vec_x_out, want.x));
        if (vec_y_out !== want.y)
          report_mismatch($sformatf("vec_y_out got %0d want %0d", vec_y_out, want.y));
      end
    end
  end

  // watchdog: cycles without any request moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic test_equal_distances;
    send_mv(16'sd5, 16'sd5, 16'sd1234, -16'sd4321);
    send_mv(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
    send_mv(16'sd0, 16'sd0, -16'sd1, 16'sd1);
    send_mv(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767);
  endtask

  task automatic test_zero_candidate;
    send_mv(16'sd7, 16'sd0, 16'sd100, -16'sd100);
    send_mv(-16'sd32768, 16'sd0, 16'sd32767, -16'sd32768);
    send_mv(16'sd32767, 16'sd0, -16'sd5, 16'sd5);
  endtask

  task automatic test_clipped_distances;
    send_mv(16'sd32767, -16'sd32768, 16'sd1000, -16'sd1000);
    send_mv(16'sd1000, 16'sd2000, 16'sd4567, -16'sd4567);
    send_mv(16'sd300, -16'sd200, 16'sd77, 16'sd300);
    send_mv(-16'sd129, 16'sd128, -16'sd256, 16'sd255);
  endtask

  task automatic test_saturation;
    send_mv(16'sd127, 16'sd1, 16'sd32767, -16'sd32768);
    send_mv(16'sd127, -16'sd1, -16'sd32768, 16'sd32767);
    send_mv(-16'sd128, 16'sd1, 16'sd32767, -16'sd32768);
    send_mv(-16'sd128, -16'sd1, 16'sd20000, -16'sd20000);
    send_mv(16'sd8, 16'sd1, 16'sd16, -16'sd17);
  endtask

  task automatic test_rounding;
    send_mv(16'sd1, 16'sd2, 16'sd1, -16'sd1);
    send_mv(16'sd1, 16'sd2, 16'sd3, -16'sd3);
    send_mv(-16'sd3, 16'sd7, 16'sd0, 16'sd255);
    send_mv(16'sd2, -16'sd3, -16'sd129, 16'sd129);
    send_mv(16'sd1, 16'sd127, 16'sd32767, -16'sd32768);
  endtask

  task automatic test_random(input int count);
    logic signed [DIST_W-1:0] tb;
    logic signed [DIST_W-1:0] td;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    for (int i = 0; i < count; i++) begin
      vx = VEC_W'($urandom());
      vy = VEC_W'($urandom());
      case ($urandom_range(0, 9))
        0: begin
          tb = DIST_W'($urandom());
          td = tb;
        end
        1: begin
          tb = DIST_W'($urandom());
          td = '0;
        end
        2: begin
          tb = DIST_W'($urandom());
          td = DIST_W'($urandom());
        end
        default: begin
          tb = DIST_W'(int'($urandom_range(0, 255)) - 128);
          td = DIST_W'(int'($urandom_range(0, 255)) - 128);
          if ($urandom_range(0, 1)) begin
            vx = VEC_W'(int'($urandom_range(0, 1023)) - 512);
            vy = VEC_W'(int'($urandom_range(0, 1023)) - 512);
          end
        end
      endcase
      send_mv(tb, td, vx, vy);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct   = 15;
    sink_stall_pct = 49;
    test_equal_distances();
    test_zero_candidate();
    test_clipped_distances();
    test_saturation();
    test_rounding();
    test_random(250);

    src_idle_pct   = 49;
    sink_stall_pct = 15;
    test_random(250);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random(250);

    in_valid <= 1'b0;
    while (expected_mv.size() != 0) @(posedge clk);
    repeat (STAGES * 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
